### rtl/tcw_pkg.sv
// Shared types, constants and helper functions of the text console writer.
// Used by tcw_screen_ram, tcw_ctrl and text_console_writer; depends on nothing.
package tcw_pkg;

  localparam int COLS  = 80;
  localparam int ROWS  = 25;
  localparam int CELLS = COLS * ROWS;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int ADDR_W = $clog2(CELLS);
  localparam int CELL_W = 16;
  localparam int RGB_W  = 24;
  localparam int ATTR_W = 8;

  localparam logic [COL_W-1:0]  COL_LIM    = COL_W'(COLS);
  localparam logic [ROW_W-1:0]  LAST_ROW   = ROW_W'(ROWS - 1);
  localparam logic [ADDR_W-1:0] COPY_END   = ADDR_W'(CELLS - COLS);
  localparam logic [ADDR_W-1:0] LAST_CELL  = ADDR_W'(CELLS - 1);
  localparam logic [CELL_W-1:0] RESET_CELL = 16'h0F20;

  localparam logic [7:0] CH_NL    = 8'd10;
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_SPACE = 8'h20;

  typedef enum logic [1:0] {
    OP_PUT   = 2'd0,
    OP_SET   = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_FG        = 2'd0,
    REG_BG        = 2'd1,
    REG_CURSOR_ON = 2'd2,
    REG_NONE      = 2'd3
  } reg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PUT,
    ST_READ,
    ST_SCROLL,
    ST_FILL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic              we;
    logic [ADDR_W-1:0] waddr;
    logic [CELL_W-1:0] wdata;
    logic              re;
    logic [ADDR_W-1:0] raddr;
  } mem_req_t;

  // Indexed by {r[1:0], g[1:0], b[1:0]}.
  localparam logic [3:0] COLOR_MAP [64] = '{
    4'd0,  4'd1,  4'd1,  4'd9,  4'd2,  4'd3,  4'd1,  4'd9,
    4'd2,  4'd2,  4'd3,  4'd9,  4'd10, 4'd10, 4'd10, 4'd11,
    4'd4,  4'd5,  4'd1,  4'd9,  4'd6,  4'd8,  4'd1,  4'd9,
    4'd2,  4'd2,  4'd3,  4'd9,  4'd10, 4'd10, 4'd10, 4'd11,
    4'd4,  4'd4,  4'd5,  4'd9,  4'd6,  4'd4,  4'd5,  4'd9,
    4'd6,  4'd6,  4'd7,  4'd9,  4'd10, 4'd10, 4'd10, 4'd11,
    4'd12, 4'd12, 4'd12, 4'd13, 4'd12, 4'd12, 4'd12, 4'd13,
    4'd12, 4'd12, 4'd12, 4'd13, 4'd14, 4'd14, 4'd14, 4'd15
  };

  function automatic logic [3:0] quantize(input logic [RGB_W-1:0] rgb);
    logic [5:0] idx;
    idx = {rgb[23:22], rgb[15:14], rgb[7:6]};
    return COLOR_MAP[idx];
  endfunction

  // Linear cell index, one bit wider than a store address.
  function automatic logic [ADDR_W:0] cell_addr(input logic [ROW_W-1:0] row,
                                                input logic [COL_W-1:0] col);
    return (ADDR_W+1)'(row) * (ADDR_W+1)'(COLS) + (ADDR_W+1)'(col);
  endfunction

endpackage

### rtl/tcw_screen_ram.sv
// Character cell store: one write port and one read port with registered read data.
// Depends on tcw_pkg for sizes and the request struct.
module tcw_screen_ram (
  input  logic                          clk,
  input  tcw_pkg::mem_req_t             req,
  output logic [tcw_pkg::CELL_W-1:0]    rd_data
);
  import tcw_pkg::*;

  logic [CELL_W-1:0] mem [CELLS];

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (req.re) begin
      rd_data <= mem[req.raddr];
    end
  end

endmodule

### rtl/tcw_ctrl.sv
// Sequencer of the console: position registers, store sweeps and the result register.
// Depends on tcw_pkg; drives the request port of tcw_screen_ram.
module tcw_ctrl (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [7:0]                    char_code,
  input  logic [7:0]                    new_col,
  input  logic [7:0]                    new_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::ADDR_W-1:0]    cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value,
  output logic [tcw_pkg::COL_W-1:0]     col_now,
  output logic [tcw_pkg::ROW_W-1:0]     row_now,
  input  logic [tcw_pkg::ATTR_W-1:0]    attr,
  input  logic                          cursor_on,
  output tcw_pkg::mem_req_t             mem_req,
  input  logic [tcw_pkg::CELL_W-1:0]    rd_data
);
  import tcw_pkg::*;

  state_t             state, state_next, fill_next;
  op_t                op, op_q;
  logic [7:0]         ch_q;
  logic [CELL_W-1:0]  cell_q;
  logic [CELL_W-1:0]  fill_val;
  logic [ADDR_W-1:0]  fill_idx;
  logic [ADDR_W-1:0]  copy_addr;
  logic               copy_wr;
  logic [COL_W-1:0]   cur_col;
  logic [ROW_W-1:0]   cur_row;
  logic [ADDR_W-1:0]  cursor_reg;
  logic [ADDR_W-1:0]  cursor_new;

  logic               is_nl, is_cr, wrap, last_row, out_free;
  logic [COL_W-1:0]   col_clamp;
  logic [ROW_W-1:0]   row_clamp;
  logic [ADDR_W:0]    rd_lin, cur_lin;
  logic [ADDR_W-1:0]  cur_lim;

  assign op       = op_t'(opcode);
  assign is_nl    = (char_code == CH_NL);
  assign is_cr    = (char_code == CH_CR);
  assign wrap     = (cur_col >= COL_LIM);
  assign last_row = (cur_row >= LAST_ROW);
  assign out_free = !out_valid || out_ready;

  assign col_clamp = (new_col >= 8'(COLS)) ? COL_W'(COLS - 1) : new_col[COL_W-1:0];
  assign row_clamp = (new_row >= 8'(ROWS)) ? ROW_W'(ROWS - 1) : new_row[ROW_W-1:0];
  assign rd_lin    = cell_addr(row_clamp, col_clamp);
  assign cur_lin   = cell_addr(cur_row, cur_col);
  assign cur_lim   = (cur_lin >= (ADDR_W+1)'(CELLS)) ? LAST_CELL : cur_lin[ADDR_W-1:0];
  assign cursor_new = ((op_q != OP_READ) && cursor_on) ? cur_lim : cursor_reg;

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          unique case (op)
            OP_PUT: begin
              priority if (is_nl) begin
                state_next = last_row ? ST_SCROLL : ST_DONE;
              end else if (is_cr) begin
                state_next = ST_DONE;
              end else if (wrap && last_row) begin
                state_next = ST_SCROLL;
              end else begin
                state_next = ST_PUT;
              end
            end
            OP_SET:   state_next = ST_DONE;
            OP_READ:  state_next = ST_READ;
            OP_CLEAR: state_next = ST_FILL;
            default:  state_next = ST_IDLE;
          endcase
        end
      end
      ST_SCROLL: if (fill_idx == COPY_END) state_next = ST_FILL;
      ST_FILL:   if (fill_idx == LAST_CELL) state_next = fill_next;
      ST_PUT:    state_next = ST_DONE;
      ST_READ:   state_next = ST_DONE;
      ST_DONE:   if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // Handshake and store requests.
  always_comb begin
    in_ready = (state == ST_IDLE);
    mem_req  = '0;
    // The copy write comes in the cycle after its read and can spill into the first fill
    // cycle only in name: the last scroll cycle issues no read, so the two never meet.
    priority if (copy_wr) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = copy_addr;
      mem_req.wdata = rd_data;
    end else if (state == ST_FILL) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = fill_idx;
      mem_req.wdata = fill_val;
    end else if (state == ST_PUT) begin
      mem_req.we    = 1'b1;
      mem_req.waddr = cur_lin[ADDR_W-1:0];
      mem_req.wdata = {attr, ch_q};
    end else begin
      mem_req.we = 1'b0;
    end
    priority if (state == ST_IDLE && in_valid && op == OP_READ) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = rd_lin[ADDR_W-1:0];
    end else if (state == ST_SCROLL && fill_idx < COPY_END) begin
      mem_req.re    = 1'b1;
      mem_req.raddr = fill_idx + ADDR_W'(COLS);
    end else begin
      mem_req.re = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_FILL;
      fill_next  <= ST_IDLE;
      fill_idx   <= '0;
      fill_val   <= RESET_CELL;
      cur_col    <= '0;
      cur_row    <= '0;
      cursor_reg <= '0;
      copy_wr    <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      state     <= state_next;
      copy_wr   <= (state == ST_SCROLL) && (fill_idx < COPY_END);
      copy_addr <= fill_idx;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            op_q     <= op;
            ch_q     <= char_code;
            cell_q   <= '0;
            fill_idx <= '0;
            fill_val <= {attr, CH_SPACE};
            unique case (op)
              OP_PUT: begin
                if (is_nl || (!is_cr && wrap)) begin
                  cur_col   <= '0;
                  fill_next <= is_nl ? ST_DONE : ST_PUT;
                  if (!last_row) begin
                    cur_row <= cur_row + 1'b1;
                  end
                end else if (is_cr) begin
                  cur_col <= '0;
                end
              end
              OP_SET: begin
                cur_col <= col_clamp;
                cur_row <= row_clamp;
              end
              OP_READ: begin
                cur_col <= cur_col;
              end
              OP_CLEAR: begin
                cur_col   <= '0;
                cur_row   <= '0;
                fill_next <= ST_DONE;
              end
              default: begin
                cur_col <= cur_col;
              end
            endcase
          end
        end
        ST_SCROLL: begin
          if (fill_idx != COPY_END) begin
            fill_idx <= fill_idx + 1'b1;
          end
        end
        ST_FILL: begin
          fill_idx <= (fill_idx == LAST_CELL) ? '0 : fill_idx + 1'b1;
        end
        ST_PUT: begin
          cur_col <= cur_col + 1'b1;
        end
        ST_READ: begin
          cell_q <= rd_data;
        end
        ST_DONE: begin
          if (out_free) begin
            cursor_reg <= cursor_new;
            cursor_pos <= cursor_new;
            cell_value <= cell_q;
            col_now    <= cur_col;
            row_now    <= cur_row;
          end
        end
        default: ;
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_wr_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_req.we |-> (mem_req.waddr <= LAST_CELL))
    else $error("store write beyond the last cell");

  a_rd_in_range: assert property (@(posedge clk) disable iff (rst)
    mem_req.re |-> (mem_req.raddr <= LAST_CELL))
    else $error("store read beyond the last cell");

  a_pos_bounds: assert property (@(posedge clk) disable iff (rst)
    (cur_row <= LAST_ROW) && (cur_col <= COL_LIM))
    else $error("write position out of bounds");

  a_no_copy_when_idle: assert property (@(posedge clk) disable iff (rst)
    in_ready |-> !copy_wr)
    else $error("scroll copy still pending while taking a word");

  a_fill_ends: assert property (@(posedge clk) disable iff (rst)
    (state == ST_FILL && fill_idx == LAST_CELL) |=> (state != ST_FILL && fill_idx == '0))
    else $error("fill sweep did not end after the last cell");
`endif

endmodule

### rtl/text_console_writer.sv
// Top level of the text console writer: configuration registers, color quantizing,
// the sequencer tcw_ctrl and the cell store tcw_screen_ram. Depends on tcw_pkg.
//
// An 80 by 25 text console whose cells live in one 2000-entry store with a registered
// read. After reset the block clears the store before taking its first word.
// A printable character passes through ST_PUT and a read through ST_READ; a carriage
// return, a set-position word and a newline that does not scroll go straight to
// ST_DONE. A newline on the last row, or a wrap there, scrolls the screen by walking
// the store one cell per cycle, and after a wrap the character is written. A clear
// sweeps all 2000 cells. The result sits in an output register, so the next word is
// taken while it waits. Configuration writes can affect even the word in progress.
module text_console_writer (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  logic [1:0]                    opcode,
  input  logic [7:0]                    char_code,
  input  logic [7:0]                    new_col,
  input  logic [7:0]                    new_row,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [tcw_pkg::ADDR_W-1:0]    cursor_pos,
  output logic [tcw_pkg::CELL_W-1:0]    cell_value,
  output logic [tcw_pkg::COL_W-1:0]     col_now,
  output logic [tcw_pkg::ROW_W-1:0]     row_now,
  input  logic                          cfg_we,
  input  logic [1:0]                    cfg_index,
  input  logic [tcw_pkg::RGB_W-1:0]     cfg_data
);
  import tcw_pkg::*;

  logic [RGB_W-1:0]  fg_rgb, bg_rgb;
  logic              cursor_on;
  logic [ATTR_W-1:0] attr;
  mem_req_t          mem_req;
  logic [CELL_W-1:0] rd_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      fg_rgb    <= 24'hFFFFFF;
      bg_rgb    <= '0;
      cursor_on <= 1'b1;
    end else if (cfg_we) begin
      unique case (reg_idx_t'(cfg_index))
        REG_FG:        fg_rgb    <= cfg_data;
        REG_BG:        bg_rgb    <= cfg_data;
        REG_CURSOR_ON: cursor_on <= cfg_data[0];
        default:       cursor_on <= cursor_on;
      endcase
    end
  end

  assign attr = {quantize(bg_rgb), quantize(fg_rgb)};

  tcw_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .char_code  (char_code),
    .new_col    (new_col),
    .new_row    (new_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .cursor_pos (cursor_pos),
    .cell_value (cell_value),
    .col_now    (col_now),
    .row_now    (row_now),
    .attr       (attr),
    .cursor_on  (cursor_on),
    .mem_req    (mem_req),
    .rd_data    (rd_data)
  );

  tcw_screen_ram u_ram (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

endmodule
